// File: hdl/mve_pkg.sv
// package for the matrix vector multiply engine
// holds the mode codes, field widths and the command passed from front to back
package mve_pkg;

  localparam int VAL_W    = 16;
  localparam int IDX_IN_W = 4;
  localparam int MODE_W   = 2;
  localparam int CFG_W    = 5;
  localparam int SUM_W    = 36;
  localparam int ROW_W    = 4;

  localparam logic [MODE_W-1:0] MODE_LD_MAT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LD_VEC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  localparam logic CFG_NUM_ROWS = 1'b0;
  localparam logic CFG_NUM_COLS = 1'b1;

  localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

  typedef struct packed {
    logic [MODE_W-1:0]      op;
    logic [IDX_IN_W-1:0]    row;
    logic [IDX_IN_W-1:0]    col;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

// File: hdl/mve_if.sv
// channel interfaces of the matrix vector multiply engine
// depends on mve_pkg for field widths
interface mve_in_if;
  import mve_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [IDX_IN_W-1:0]     row;
  logic [IDX_IN_W-1:0]     col;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, mode, row, col, value, input ready);
  modport sink   (input valid, mode, row, col, value, output ready);
endinterface

interface mve_out_if;
  import mve_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] product_value;
  logic [ROW_W-1:0]        row_index;
  logic                    last;

  modport source (output valid, product_value, row_index, last, input ready);
  modport sink   (input valid, product_value, row_index, last, output ready);
endinterface

// File: hdl/matrix_vector_multiply_engine.sv
// top level of the matrix vector multiply engine
// depends on mve_pkg, mve_if, mve_front, mve_fifo and mve_back
//
//   channel    dir  handshake      payload
//   in_chan    in   valid/ready    mode, row, col, value (q8.8)
//   out_chan   out  valid/ready    product_value (q20.16), row_index, last
//   cfg_*      in   cfg_we only    cfg_index selects num_rows / num_cols
//
// a load is written when the back end takes it; a compute walks the matrix row by row:
// one memory read per column, then a drain of the read and multiply-accumulate
// pipeline, then the row is emitted; a stalled result holds the walk in the emit state
// the front accepts into a two entry queue, so it queues up to two transactions while the
// back end computes or waits on a stalled result
// synchronous active-low reset clears control and sets both sizes to 16; memories
// hold no reset value
module matrix_vector_multiply_engine #(
  parameter int MAX_DIM = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  mve_in_if.sink                    in_chan,
  mve_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mve_pkg::CFG_W-1:0] cfg_wdata
);
  import mve_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM + 1);

  logic             q_push, q_full, q_pop, q_valid;
  cmd_t             push_cmd, head_cmd;
  logic [CNT_W-1:0] rows, cols;

  mve_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .rows      (rows),
    .cols      (cols)
  );

  mve_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  mve_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (head_cmd),
    .q_pop    (q_pop),
    .rows     (rows),
    .cols     (cols),
    .out_chan (out_chan)
  );

endmodule

// File: hdl/mve_fifo.sv
// two entry command queue between front and back
// depends on mve_pkg for cmd_t
module mve_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mve_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output mve_pkg::cmd_t head_cmd
);
  import mve_pkg::*;

  cmd_t       entries_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = entries_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hdl/mve_front.sv
// front end: size registers, input acceptance and load filtering
// depends on mve_pkg and mve_in_if
module mve_front #(
  parameter int MAX_DIM = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [mve_pkg::CFG_W-1:0]       cfg_wdata,
  mve_in_if.sink                          in_chan,
  input  logic                            q_full,
  output logic                            q_push,
  output mve_pkg::cmd_t                   q_cmd,
  output logic [$clog2(MAX_DIM+1)-1:0]    rows,
  output logic [$clog2(MAX_DIM+1)-1:0]    cols
);
  import mve_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int DIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] num_rows_r, num_cols_r;
  logic [DIM_W-1:0] rows_ext, cols_ext;
  logic             keep;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] reg_val);
    logic [DIM_W-1:0] v;
    v = DIM_W'(reg_val);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= DIM_RESET;
      num_cols_r <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_ROWS: num_rows_r <= cfg_wdata;
        CFG_NUM_COLS: num_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign rows_ext = eff_dim(num_rows_r);
  assign cols_ext = eff_dim(num_cols_r);
  assign rows     = CNT_W'(rows_ext);
  assign cols     = CNT_W'(cols_ext);

  // drop out-of-range loads and the unused mode
  always_comb begin
    keep = 1'b0;
    priority if (in_chan.mode == MODE_LD_MAT) begin
      keep = (DIM_W'(in_chan.row) < rows_ext) && (DIM_W'(in_chan.col) < cols_ext);
    end else if (in_chan.mode == MODE_LD_VEC) begin
      keep = (DIM_W'(in_chan.col) < cols_ext);
    end else if (in_chan.mode == MODE_COMPUTE) begin
      keep = 1'b1;
    end else begin
      keep = 1'b0;
    end
  end

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full && keep;

  always_comb begin
    q_cmd.op    = in_chan.mode;
    q_cmd.row   = in_chan.row;
    q_cmd.col   = in_chan.col;
    q_cmd.value = in_chan.value;
  end

endmodule

// File: hdl/mve_back.sv
// back end: matrix and vector memories, multiply-accumulate walk and result register
// depends on mve_pkg and mve_out_if
module mve_back #(
  parameter int MAX_DIM = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  mve_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  input  logic [$clog2(MAX_DIM+1)-1:0]  rows,
  input  logic [$clog2(MAX_DIM+1)-1:0]  cols,
  mve_out_if.source                     out_chan
);
  import mve_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int MEM_D = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(MEM_D);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [VAL_W-1:0]          mat_mem [MEM_D];
  logic [VAL_W-1:0]          vec_mem [MAX_DIM];

  logic [1:0]                state_r, state_nxt;
  logic [IDX_W-1:0]          r_r, r_nxt, c_r, c_nxt;
  logic                      rd_vld_r, mul_vld_r;
  logic signed [VAL_W-1:0]   mat_q_r, vec_q_r;
  logic signed [2*VAL_W-1:0] prod_r;
  logic signed [SUM_W-1:0]   acc_r, acc_nxt;
  logic                      out_vld_r;
  logic signed [SUM_W-1:0]   out_val_r;
  logic [ROW_W-1:0]          out_row_r;
  logic                      out_last_r;

  logic                      issue, row_end, last_row, out_free, emit;
  logic                      mat_we, vec_we;
  logic [AW-1:0]             wr_addr, rd_addr;

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign mat_we   = q_pop && (q_cmd.op == MODE_LD_MAT);
  assign vec_we   = q_pop && (q_cmd.op == MODE_LD_VEC);
  assign wr_addr  = AW'(IDX_W'(q_cmd.row)) * AW'(MAX_DIM) + AW'(IDX_W'(q_cmd.col));
  assign rd_addr  = AW'(r_r) * AW'(MAX_DIM) + AW'(c_r);
  assign issue    = (state_r == ST_ISSUE);
  assign row_end  = (CNT_W'(c_r) == cols - CNT_W'(1));
  assign last_row = (CNT_W'(r_r) == rows - CNT_W'(1));
  assign out_free = !out_vld_r || out_chan.ready;
  assign emit     = (state_r == ST_EMIT) && out_free;

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    acc_nxt   = acc_r;
    if (mul_vld_r) begin
      acc_nxt = acc_r + SUM_W'(prod_r);
    end
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop && (q_cmd.op == MODE_COMPUTE)) begin
          state_nxt = ST_ISSUE;
          r_nxt     = '0;
          c_nxt     = '0;
          acc_nxt   = '0;
        end
      end
      ST_ISSUE: begin
        if (row_end) begin
          state_nxt = ST_DRAIN;
          c_nxt     = '0;
        end else begin
          c_nxt = c_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !mul_vld_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (last_row) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_ISSUE;
            r_nxt     = r_r + IDX_W'(1);
            acc_nxt   = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= issue;
      mul_vld_r <= rd_vld_r;
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    r_r    <= r_nxt;
    c_r    <= c_nxt;
    acc_r  <= acc_nxt;
    prod_r <= mat_q_r * vec_q_r;
    if (emit) begin
      out_val_r  <= acc_r;
      out_row_r  <= ROW_W'(r_r);
      out_last_r <= last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[wr_addr] <= q_cmd.value;
    end
    if (issue) begin
      mat_q_r <= mat_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[IDX_W'(q_cmd.col)] <= q_cmd.value;
    end
    if (issue) begin
      vec_q_r <= vec_mem[c_r];
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.product_value = out_val_r;
  assign out_chan.row_index     = out_row_r;
  assign out_chan.last          = out_last_r;

endmodule
